// ===== rtl/deq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

	localparam int WORD_W   = 32;
	localparam int POS_W    = 16;
	localparam int OCC_W    = 7;
	localparam int STATUS_W = 2;

	// request operation codes
	typedef enum logic [2:0] {
		KIND_PUSH_FRONT = 3'd0,
		KIND_PUSH_REAR  = 3'd1,
		KIND_INSERT_AT  = 3'd2,
		KIND_POP_FRONT  = 3'd3,
		KIND_POP_REAR   = 3'd4,
		KIND_PEEK_FRONT = 3'd5,
		KIND_PEEK_REAR  = 3'd6,
		KIND_CLEAR      = 3'd7
	} kind_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_INS_WR,
		S_RESP
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/double_ended_queue_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// deque of signed words held in a ring memory, one request at a time
// front push, insert at index 0, pops, peeks and clear: S_EXEC, then S_RESP
// rear push and insert at a position: S_EXEC, an S_SHIFT_RD/S_SHIFT_WR pair per entry
// moved (memory read then write), S_INS_WR, then S_RESP; when full, straight to S_RESP
// front reads use head_q, others one shared mod-DEPTH adder; a held result beat stalls input
// arst_n clears the sequencer, head index, fill count and output valid; memory is not cleared

module double_ended_queue_unit
	import deq_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [2:0]                 kind,
	input  wire logic signed [WORD_W-1:0]   value,
	input  wire logic signed [POS_W-1:0]    position,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic signed [WORD_W-1:0]        read_value,
	output logic [STATUS_W-1:0]             status,
	output logic [OCC_W-1:0]                occupancy,
	output logic                            is_empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;
	localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [CW-1:0] LAST_C  = CW'(DEPTH - 1);

	state_t state_q, state_d;

	// latched request
	kind_t                    req_kind_q;
	logic [WORD_W-1:0]        req_value_q;
	logic [POS_W-1:0]         req_pos_q;

	logic [AW-1:0]            head_q;
	logic [CW-1:0]            count_q;
	logic [CW-1:0]            at_q;
	logic [CW-1:0]            idx_q;
	status_t                  res_status_q;
	logic                     res_mem_q;

	logic                     out_valid_q;
	logic [WORD_W-1:0]        read_value_q;
	logic [STATUS_W-1:0]      status_q;
	logic [OCC_W-1:0]         occupancy_q;
	logic                     is_empty_q;

	logic                     full;
	logic                     empty;
	logic [CW-1:0]            at_c;
	logic                     front_ins;
	logic                     rear_ins;
	logic                     resp_load;

	logic [CW-1:0]            slot_off;
	logic [SW-1:0]            slot_sum;
	logic [SW-1:0]            slot_red;
	logic [AW-1:0]            slot_addr;

	logic                     mem_we;
	logic [AW-1:0]            mem_waddr;
	logic [WORD_W-1:0]        mem_wdata;
	logic                     mem_re;
	logic [AW-1:0]            mem_raddr;
	logic [WORD_W-1:0]        mem_rdata;
	logic [CW-1:0]            idx_dec;
	logic [POS_W-1:0]         count_ext;

	assign full  = (count_q == DEPTH_C);
	assign empty = (count_q == '0);
	assign idx_dec = idx_q - CW'(1);

	// insert index: rear push and beyond the fill go to the rear, negative goes to the front
	assign count_ext = POS_W'(count_q);
	always_comb begin
		if (req_kind_q == KIND_PUSH_REAR) begin
			at_c = count_q;
		end else if (req_pos_q[POS_W-1]) begin
			at_c = '0;
		end else if (req_pos_q < count_ext) begin
			at_c = CW'(req_pos_q);
		end else begin
			at_c = count_q;
		end
	end

	assign front_ins = (req_kind_q == KIND_PUSH_FRONT) ||
	                   ((req_kind_q == KIND_INSERT_AT) && (at_c == '0));
	assign rear_ins  = ((req_kind_q == KIND_PUSH_REAR) || (req_kind_q == KIND_INSERT_AT)) &&
	                   !front_ins;

	assign resp_load = (state_q == S_RESP) && (!out_valid_q || out_ready);

	// shared slot unit: (head + offset) mod DEPTH
	assign slot_sum  = SW'(head_q) + SW'(slot_off);
	assign slot_red  = (slot_sum >= DEPTH_S) ? (slot_sum - DEPTH_S) : slot_sum;
	assign slot_addr = slot_red[AW-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (rear_ins && !full) begin
					state_d = (count_q > at_c) ? S_SHIFT_RD : S_INS_WR;
				end else begin
					state_d = S_RESP;
				end
			end
			S_SHIFT_RD: begin
				state_d = S_SHIFT_WR;
			end
			S_SHIFT_WR: begin
				state_d = (idx_dec > at_q) ? S_SHIFT_RD : S_INS_WR;
			end
			S_INS_WR: begin
				state_d = S_RESP;
			end
			S_RESP: begin
				if (resp_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// sequencer outputs: slot offset and memory strobes
	always_comb begin
		slot_off  = '0;
		mem_we    = 1'b0;
		mem_waddr = slot_addr;
		mem_wdata = req_value_q;
		mem_re    = 1'b0;
		mem_raddr = slot_addr;
		case (state_q)
			S_EXEC: begin
				case (req_kind_q)
					KIND_PUSH_FRONT, KIND_PUSH_REAR, KIND_INSERT_AT: begin
						slot_off = LAST_C;
						mem_we   = front_ins && !full;
					end
					KIND_POP_FRONT, KIND_PEEK_FRONT: begin
						slot_off  = CW'(1);
						mem_re    = !empty;
						mem_raddr = head_q;
					end
					KIND_POP_REAR, KIND_PEEK_REAR: begin
						slot_off = count_q - CW'(1);
						mem_re   = !empty;
					end
					default: begin
						slot_off = '0;
					end
				endcase
			end
			S_SHIFT_RD: begin
				slot_off = idx_dec;
				mem_re   = 1'b1;
			end
			S_SHIFT_WR: begin
				slot_off  = idx_q;
				mem_we    = 1'b1;
				mem_wdata = mem_rdata;
			end
			S_INS_WR: begin
				slot_off = at_q;
				mem_we   = 1'b1;
			end
			default: begin
				slot_off = '0;
			end
		endcase
	end

	assign in_ready = (state_q == S_IDLE);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (resp_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_EXEC: begin
					case (req_kind_q)
						KIND_PUSH_FRONT, KIND_PUSH_REAR, KIND_INSERT_AT: begin
							if (!full && front_ins) begin
								head_q  <= slot_addr;
								count_q <= count_q + CW'(1);
							end
						end
						KIND_POP_FRONT: begin
							if (!empty) begin
								head_q  <= slot_addr;
								count_q <= count_q - CW'(1);
							end
						end
						KIND_POP_REAR: begin
							if (!empty) begin
								count_q <= count_q - CW'(1);
							end
						end
						KIND_CLEAR: begin
							count_q <= '0;
						end
						default: begin
							count_q <= count_q;
						end
					endcase
				end
				S_INS_WR: begin
					count_q <= count_q + CW'(1);
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

	// request and working registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_kind_q  <= kind_t'(kind);
			req_value_q <= value;
			req_pos_q   <= position;
		end
		case (state_q)
			S_EXEC: begin
				at_q         <= at_c;
				idx_q        <= count_q;
				res_status_q <= ST_OK;
				res_mem_q    <= 1'b0;
				case (req_kind_q)
					KIND_PUSH_FRONT, KIND_PUSH_REAR, KIND_INSERT_AT: begin
						if (full) begin
							res_status_q <= ST_FULL;
						end
					end
					KIND_POP_FRONT, KIND_PEEK_FRONT, KIND_POP_REAR, KIND_PEEK_REAR: begin
						if (empty) begin
							res_status_q <= ST_EMPTY;
						end else begin
							res_mem_q <= 1'b1;
						end
					end
					default: begin
						res_mem_q <= 1'b0;
					end
				endcase
			end
			S_SHIFT_WR: begin
				idx_q <= idx_dec;
			end
			default: begin
				idx_q <= idx_q;
			end
		endcase
	end

	// result beat register
	always_ff @(posedge clk) begin
		if (resp_load) begin
			if (res_mem_q) begin
				read_value_q <= mem_rdata;
			end else if (res_status_q == ST_EMPTY) begin
				read_value_q <= '1;
			end else begin
				read_value_q <= '0;
			end
			status_q    <= res_status_q;
			occupancy_q <= OCC_W'(count_q);
			is_empty_q  <= empty;
		end
	end

	deq_ram #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.W     (WORD_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;
	assign status     = status_q;
	assign occupancy  = occupancy_q;
	assign is_empty   = is_empty_q;

	// fill never passes the ring size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("fill count beyond ring size");

	// one request at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("accepted while busy");

	// empty result carries the empty marker word
	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_EMPTY) |-> (read_value == -32'sd1 && is_empty))
		else $error("empty result without marker word");

	// shift loop never runs below the insert index
	a_shift_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT_RD) |-> (idx_q > at_q))
		else $error("shift index below insert point");

endmodule

`default_nettype wire

// ===== rtl/deq_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module deq_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int W     = 32
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [W-1:0]  wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];

	// one write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// one registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire
